[sv/tfd_pkg.sv]
// Shared types and format codes for the texel format decoder.
package tfd_pkg;

    localparam logic [3:0] FMT_RGBA8888 = 4'd1;
    localparam logic [3:0] FMT_RGBA5551 = 4'd2;
    localparam logic [3:0] FMT_CI4      = 4'd3;
    localparam logic [3:0] FMT_CI8      = 4'd4;
    localparam logic [3:0] FMT_I4       = 4'd5;
    localparam logic [3:0] FMT_I8       = 4'd6;
    localparam logic [3:0] FMT_IA31     = 4'd7;
    localparam logic [3:0] FMT_IA44     = 4'd8;
    localparam logic [3:0] FMT_IA88     = 4'd9;

    typedef struct packed {
        logic [7:0] texel_byte;
        logic       last_byte;
    } tfd_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] palette_index;
        logic       indexed;
        logic       last_pixel;
    } tfd_out_t;

    typedef struct packed {
        logic [3:0]  fmt;
        logic [31:0] word;
        logic        last;
    } tfd_job_t;

endpackage

[sv/texel_format_decoder_top.sv]
// Top level of the texel format decoder: front end, job queue, back end.
//
//   channel   direction  handshake                    beat
//   config    in         cfg_we                       cfg_data, format code
//   byte      in         byte_valid / byte_stall      tfd_in_t
//   pixel     out        pixel_valid / pixel_stall    tfd_out_t
//
// One byte beat per cycle enters while the queue has room; the back end sends one
// pixel per cycle while pixel_stall is low, so 4-bit formats give two pixels per byte.
// From byte to pixel the data is registered in the queue, then in the output register.
// rst_n clears the format register, gathered bytes, queue and output valid.
// Output stall backs up through the queue; the front stalls only when it is full.
module texel_format_decoder_top #(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_data,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  tfd_pkg::tfd_in_t   byte_data,
    output logic               pixel_valid,
    input  logic               pixel_stall,
    output tfd_pkg::tfd_out_t  pixel_data
);

    logic              job_push;
    logic              job_full;
    logic              job_pop;
    logic              job_empty;
    tfd_pkg::tfd_job_t job_in;
    tfd_pkg::tfd_job_t job_head;

    tfd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .job_push   (job_push),
        .job_data   (job_in),
        .job_full   (job_full)
    );

    tfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .head      (job_head),
        .empty     (job_empty)
    );

    tfd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (job_head),
        .empty       (job_empty),
        .pop         (job_pop),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_data  (pixel_data)
    );

endmodule

[sv/tfd_front.sv]
// Front end: format register, byte gathering and job issue into the queue.
module tfd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_data,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  tfd_pkg::tfd_in_t   byte_data,
    output logic               job_push,
    output tfd_pkg::tfd_job_t  job_data,
    input  logic               job_full
);

    logic [3:0]  fmt_reg;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [23:0] held_reg;
    logic [23:0] held_next;
    logic        accept;
    logic [2:0]  need;
    logic [31:0] word;

    assign byte_stall = job_full;
    assign accept     = byte_valid && !job_full;

    always_comb
    begin
        need       = (fmt_reg == tfd_pkg::FMT_RGBA8888) ? 3'd4 : 3'd2;
        word       = {8'd0, held_reg} | ({24'd0, byte_data.texel_byte} << {phase_reg, 3'b000});
        phase_next = phase_reg;
        held_next  = held_reg;
        job_push   = 1'b0;
        job_data.fmt  = fmt_reg;
        job_data.word = word;
        job_data.last = byte_data.last_byte;
        if (accept)
        begin
            if (fmt_reg inside {tfd_pkg::FMT_RGBA8888, tfd_pkg::FMT_RGBA5551,
                                tfd_pkg::FMT_IA88})
            begin
                if (({1'b0, phase_reg} + 3'd1 < need) && !byte_data.last_byte)
                begin
                    held_next  = word[23:0];
                    phase_next = phase_reg + 2'd1;
                end
                else
                begin
                    job_push   = 1'b1;
                    held_next  = '0;
                    phase_next = '0;
                end
            end
            else if (fmt_reg inside {[tfd_pkg::FMT_CI4 : tfd_pkg::FMT_IA44]})
            begin
                job_push      = 1'b1;
                job_data.word = {24'd0, byte_data.texel_byte};
                held_next     = '0;
                phase_next    = '0;
            end
            else if (byte_data.last_byte)
            begin
                held_next  = '0;
                phase_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= '0;
            phase_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                fmt_reg <= cfg_data;
            end
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

[sv/tfd_queue.sv]
// Small job queue between front and back end.
module tfd_queue #(
    parameter int DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tfd_pkg::tfd_job_t  push_data,
    output logic               full,
    input  logic               pop,
    output tfd_pkg::tfd_job_t  head,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tfd_pkg::tfd_job_t mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/tfd_back.sv]
// Back end: expands queued jobs into pixels and holds the output register.
module tfd_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  tfd_pkg::tfd_job_t  head,
    input  logic               empty,
    output logic               pop,
    output logic               pixel_valid,
    input  logic               pixel_stall,
    output tfd_pkg::tfd_out_t  pixel_data
);

    logic              sub_reg;
    logic              sub_next;
    logic              valid_reg;
    logic              valid_next;
    tfd_pkg::tfd_out_t pix_reg;
    tfd_pkg::tfd_out_t pix;
    logic              load;
    logic              two;
    logic [7:0]        s0;
    logic [7:0]        s1;
    logic [15:0]       d;
    logic [3:0]        nib;

    assign load        = !valid_reg || !pixel_stall;
    assign pixel_valid = valid_reg;
    assign pixel_data  = pix_reg;

    always_comb
    begin
        s0  = head.word[7:0];
        s1  = head.word[15:8];
        d   = {s0, s1};
        nib = sub_reg ? s0[3:0] : s0[7:4];
        two = head.fmt inside {tfd_pkg::FMT_CI4, tfd_pkg::FMT_I4, tfd_pkg::FMT_IA31};
        pix.palette_index = '0;
        pix.indexed       = 1'b0;
        pix.last_pixel    = head.last && (!two || sub_reg);
        pix.alpha         = 8'hFF;
        pix.red           = s0;
        case (head.fmt)
            tfd_pkg::FMT_RGBA8888:
            begin
                pix.alpha = head.word[31:24];
            end
            tfd_pkg::FMT_RGBA5551:
            begin
                pix.red   = {d[15:11], 3'b000};
                pix.alpha = {8{d[0]}};
            end
            tfd_pkg::FMT_CI4:
            begin
                pix.red           = {nib, 4'h0};
                pix.palette_index = {4'h0, nib};
                pix.indexed       = 1'b1;
            end
            tfd_pkg::FMT_CI8:
            begin
                pix.palette_index = s0;
                pix.indexed       = 1'b1;
            end
            tfd_pkg::FMT_I4:
            begin
                pix.red = {nib, 4'h0};
            end
            tfd_pkg::FMT_IA31:
            begin
                pix.red   = {nib[3:1], 5'd0};
                pix.alpha = {8{nib[0]}};
            end
            tfd_pkg::FMT_IA44:
            begin
                pix.red   = {s0[7:4], 4'h0};
                pix.alpha = {s0[3:0], 4'h0};
            end
            tfd_pkg::FMT_IA88:
            begin
                pix.alpha = s1;
            end
            default:
            begin
                pix.red = s0;
            end
        endcase
        pix.green = pix.red;
        pix.blue  = pix.red;
        case (head.fmt)
            tfd_pkg::FMT_RGBA8888:
            begin
                pix.green = s1;
                pix.blue  = head.word[23:16];
            end
            tfd_pkg::FMT_RGBA5551:
            begin
                pix.green = {d[10:6], 3'b000};
                pix.blue  = {d[5:1], 3'b000};
            end
            default:
            begin
                pix.green = pix.red;
            end
        endcase

        pop        = 1'b0;
        sub_next   = sub_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                if (two && !sub_reg)
                begin
                    sub_next = 1'b1;
                end
                else
                begin
                    sub_next = 1'b0;
                    pop      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            pix_reg <= pix;
        end
    end

endmodule
